// ----- hw/rtl/id3fw_pkg.sv -----
// Shared definitions for the tag frame walker: the table of known frame IDs
// and the result record passed from the walker core to the top level.
// Depends on nothing.
`default_nettype none

package id3fw_pkg;

   localparam int TABLE_IDS = 84;

   localparam logic [31:0] KNOWN_IDS [TABLE_IDS] = '{
      "AENC", "APIC", "ASPI", "COMM", "COMR", "ENCR", "EQU2", "ETCO",
      "GEOB", "GRID", "LINK", "MCDI", "MLLT", "OWNE", "PRIV", "PCNT",
      "POPM", "POSS", "RBUF", "RVA2", "RVRB", "SEEK", "SIGN", "SYLT",
      "SYTC", "TALB", "TBPM", "TCOM", "TCON", "TCOP", "TDEN", "TDLY",
      "TDOR", "TDRC", "TDRL", "TDTG", "TENC", "TEXT", "TFLT", "TIPL",
      "TIT1", "TIT2", "TIT3", "TKEY", "TLAN", "TLEN", "TMCL", "TMED",
      "TMOO", "TOAL", "TOFN", "TOLY", "TOPE", "TOWN", "TPE1", "TPE2",
      "TPE3", "TPE4", "TPOS", "TPRO", "TPUB", "TRCK", "TRSN", "TRSO",
      "TSOA", "TSOP", "TSOT", "TSRC", "TSSE", "TSST", "TYER", "TXXX",
      "UFID", "USER", "USLT", "WCOM", "WCOP", "WOAF", "WOAR", "WOAS",
      "WORS", "WPAY", "WPUB", "WXXX"
   };

   typedef struct packed {
      logic        valid;
      logic [31:0] offset;
      logic        kind;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/id3fw_id_match.sv -----
// Parallel compare of one frame ID against the known ID table.
// Depends on id3fw_pkg for the table.
`default_nettype none

module id3fw_id_match #(
   parameter int ID_COUNT = 84
) (
   input  wire logic [31:0] frame_id,
   output logic             known
);

   always_comb begin
      known = 1'b0;
      for (int i = 0; i < id3fw_pkg::TABLE_IDS; i++) begin
         if ((i < ID_COUNT) && (frame_id == id3fw_pkg::KNOWN_IDS[i])) begin
            known = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/id3fw_walker.sv -----
// Walker core: phase state machine over header, ID, size and skip bytes,
// plus the saturating stream position. Depends on id3fw_pkg and id3fw_id_match.
`default_nettype none

module id3fw_walker #(
   parameter int ID_COUNT = 84
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   end_of_stream,
   output id3fw_pkg::result_type       res
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_ID     = 3'd1;
   localparam logic [2:0] PH_SIZE   = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [3:0]  HEADER_BYTES = 4'd10;
   localparam logic [3:0]  ID_LAST      = 4'd3;
   localparam logic [3:0]  SIZE_BYTES   = 4'd4;
   localparam logic [32:0] FLAG_BYTES   = 33'd2;
   localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [23:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;
   logic [32:0] remaining_ff, remaining_in;
   logic [31:0] pos_ff, pos_in;
   logic        given_ff, given_in;

   logic [31:0] frame_id;
   logic        known;
   logic        found;
   logic [31:0] found_off;
   logic [31:0] size_next;
   logic [32:0] remaining_dec;

   assign frame_id  = {id_ff, data_byte};
   assign size_next = {size_ff[23:0], data_byte};
   assign remaining_dec = (remaining_ff != '0) ? (remaining_ff - 33'd1) : remaining_ff;

   id3fw_id_match #(
      .ID_COUNT(ID_COUNT)
   ) u_id_match (
      .frame_id(frame_id),
      .known   (known)
   );

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      id_in        = id_ff;
      size_in      = size_ff;
      remaining_in = remaining_ff;
      found        = 1'b0;
      found_off    = (pos_ff >= 32'd3) ? (pos_ff - 32'd3) : '0;

      case (phase_ff)
         PH_HEADER: begin
            count_in = count_ff + 4'd1;
            if (count_in >= HEADER_BYTES) begin
               phase_in = PH_ID;
               count_in = '0;
            end
         end
         PH_ID: begin
            if (count_ff < ID_LAST) begin
               id_in    = {id_ff[15:0], data_byte};
               count_in = count_ff + 4'd1;
            end else begin
               count_in = '0;
               id_in    = '0;
               if (known) begin
                  phase_in = PH_SIZE;
                  size_in  = '0;
               end else begin
                  found    = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         PH_SIZE: begin
            size_in  = size_next;
            count_in = count_ff + 4'd1;
            if (count_in >= SIZE_BYTES) begin
               remaining_in = {1'b0, size_next} + FLAG_BYTES;
               size_in      = '0;
               count_in     = '0;
               phase_in     = PH_SKIP;
            end
         end
         PH_SKIP: begin
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_ID;
               count_in = '0;
            end
         end
         default: begin
         end
      endcase

      pos_in   = (pos_ff != POS_MAX) ? (pos_ff + 32'd1) : pos_ff;
      given_in = given_ff | found;

      res.valid  = found | (end_of_stream & ~given_ff);
      res.offset = found ? found_off : pos_in;
      res.kind   = ~found;

      if (end_of_stream) begin
         phase_in     = PH_HEADER;
         count_in     = '0;
         id_in        = '0;
         size_in      = '0;
         remaining_in = '0;
         pos_in       = '0;
         given_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         id_ff        <= '0;
         size_ff      <= '0;
         remaining_ff <= '0;
         pos_ff       <= '0;
         given_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         id_ff        <= id_in;
         size_ff      <= size_in;
         remaining_ff <= remaining_in;
         pos_ff       <= pos_in;
         given_ff     <= given_in;
      end
   end

`ifndef ASSERT_OFF
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (remaining_ff != '0))
      else $error("Skip phase entered with nothing left to skip.");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (step && res.valid && !res.kind && !end_of_stream)
      |=> (phase_ff == PH_DONE) && given_ff)
      else $error("Walk did not stop after an unknown frame ID.");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (step && end_of_stream)
      |=> (phase_ff == PH_HEADER) && (pos_ff == '0) && !given_ff)
      else $error("Walker did not rearm after the end of a stream.");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/id3v2_frame_walker.sv -----
// Top level of the tag frame walker: input word register, walker core and
// result register. Depends on id3fw_pkg and id3fw_walker.
`default_nettype none

// Takes one file byte per cycle, offset 0 first, with tlast on the last byte of
// the file, and returns at most one word per file: the offset of the first
// frame whose ID is not in the known table (tuser 0), or the byte count of the
// file when it ends before such a frame (tuser 1). A new byte is accepted every
// cycle unless a waiting result stalls the input; the walker updates its whole
// state on each accepted byte, so the rate is one byte per clock without a stall,
// and a result goes through the input register, then the result register.
// A waiting result stalls the input only when the next byte also produces a result.
module id3v2_frame_walker #(
   parameter int KNOWN_ID_COUNT = 84
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,   // end_of_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // region_end_offset
   output logic             rsp_tuser    // ending_kind
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_offset_ff;
   logic        out_kind_ff;
   logic        step;

   id3fw_pkg::result_type res;

   assign step       = in_valid_ff & (~res.valid | ~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step;

   id3fw_walker #(
      .ID_COUNT(KNOWN_ID_COUNT)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_data_ff),
      .end_of_stream(in_last_ff),
      .res          (res)
   );

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      if (step && res.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && res.valid) begin
         out_offset_ff <= res.offset;
         out_kind_ff   <= res.kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_offset_ff;
   assign rsp_tuser  = out_kind_ff;

`ifndef ASSERT_OFF
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (step && res.valid)
      |=> rsp_tvalid && (rsp_tdata == $past(res.offset)) && (rsp_tuser == $past(res.kind)))
      else $error("Result register did not take the walker result.");
`endif

endmodule

`default_nettype wire

// ----- dv/id3v2_frame_walker_checker.sv -----
// Checker for the tag frame walker: follows the byte and result channels, predicts
// the region end of every file and compares each result word with it.
// Depends on id3fw_pkg for the table of known frame IDs.
`timescale 1ns / 1ps

module id3v2_frame_walker_checker #(
   parameter int KNOWN_ID_COUNT = 84
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          failures,
   output int          pending
);

   localparam int COMPARED_IDS = KNOWN_ID_COUNT > id3fw_pkg::TABLE_IDS ?
                                 id3fw_pkg::TABLE_IDS : KNOWN_ID_COUNT;
   localparam logic [3:0] HEADER_LEN = 4'd10;
   localparam logic [3:0] ID_LEN = 4'd4;
   localparam logic [3:0] SIZE_LEN = 4'd4;
   localparam logic [32:0] FLAG_LEN = 33'd2;
   localparam logic [31:0] POSITION_MAX = 32'hFFFF_FFFF;
   localparam logic KIND_UNKNOWN_ID = 1'b0;
   localparam logic KIND_TRUNCATED = 1'b1;

   typedef enum logic [2:0] {
      WALK_HEADER,
      WALK_ID,
      WALK_SIZE,
      WALK_SKIP,
      WALK_DONE
   } walk_phase_type;

   typedef struct packed {
      logic [31:0] offset;
      logic        kind;
   } region_end_type;

   region_end_type region_end_q[$];

   walk_phase_type walk_phase;
   logic [3:0]  phase_count;
   logic [23:0] id_prefix;
   logic [31:0] size_acc;
   logic [32:0] skip_left;
   logic [31:0] position;
   logic        reported;

   function automatic bit frame_id_known(input logic [31:0] id);
      for (int i = 0; i < COMPARED_IDS; i++) begin
         if (id3fw_pkg::KNOWN_IDS[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic rearm_walk();
      walk_phase = WALK_HEADER;
      phase_count = '0;
      id_prefix = '0;
      size_acc = '0;
      skip_left = '0;
      position = '0;
      reported = 1'b0;
   endtask

   task automatic walk_byte(input logic [7:0] data_byte, input logic last_byte);
      logic [31:0] pos;
      logic [31:0] id;
      bit          found;
      logic [31:0] found_at;
      pos = position;
      found = 1'b0;
      found_at = '0;
      case (walk_phase)
         WALK_HEADER: begin
            phase_count = phase_count + 4'd1;
            if (phase_count >= HEADER_LEN) begin
               walk_phase = WALK_ID;
               phase_count = '0;
            end
         end
         WALK_ID: begin
            if (phase_count < ID_LEN - 4'd1) begin
               id_prefix = {id_prefix[15:0], data_byte};
               phase_count = phase_count + 4'd1;
            end else begin
               id = {id_prefix, data_byte};
               phase_count = '0;
               id_prefix = '0;
               if (frame_id_known(id)) begin
                  walk_phase = WALK_SIZE;
                  size_acc = '0;
               end else begin
                  found = 1'b1;
                  found_at = pos >= 32'd3 ? pos - 32'd3 : 32'd0;
                  walk_phase = WALK_DONE;
               end
            end
         end
         WALK_SIZE: begin
            size_acc = {size_acc[23:0], data_byte};
            phase_count = phase_count + 4'd1;
            if (phase_count >= SIZE_LEN) begin
               skip_left = {1'b0, size_acc} + FLAG_LEN;
               size_acc = '0;
               phase_count = '0;
               walk_phase = WALK_SKIP;
            end
         end
         WALK_SKIP: begin
            if (skip_left != '0) skip_left = skip_left - 33'd1;
            if (skip_left == '0) begin
               walk_phase = WALK_ID;
               phase_count = '0;
            end
         end
         default: begin
         end
      endcase

      if (position != POSITION_MAX) position = position + 32'd1;

      if (found) begin
         reported = 1'b1;
         region_end_q.push_back(region_end_type'{offset: found_at, kind: KIND_UNKNOWN_ID});
         if (last_byte) rearm_walk();
      end else if (last_byte) begin
         if (!reported) begin
            region_end_q.push_back(region_end_type'{offset: position, kind: KIND_TRUNCATED});
         end
         rearm_walk();
      end
   endtask

   always @(posedge clock) begin
      region_end_type want;
      if (reset) begin
         rearm_walk();
         region_end_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (region_end_q.size() == 0) begin
               if (failures < 10) begin
                  $display("unexpected word: offset %0d kind %0d", rsp_tdata, rsp_tuser);
               end
               failures <= failures + 1;
            end else begin
               want = region_end_q.pop_front();
               if (rsp_tdata !== want.offset || rsp_tuser !== want.kind) begin
                  if (failures < 10) begin
                     $display("mismatch: expected offset %0d kind %0d, got offset %0d kind %0d",
                              want.offset, want.kind, rsp_tdata, rsp_tuser);
                  end
                  failures <= failures + 1;
               end
            end
         end
         if (req_tvalid && req_tready) walk_byte(req_tdata, req_tlast);
      end
      pending <= region_end_q.size();
   end

endmodule

// ----- dv/id3v2_frame_walker_tb.sv -----
// Top of the tag frame walker testbench: clock, reset, file byte streams and the
// verdict. Depends on id3fw_pkg, id3v2_frame_walker and id3v2_frame_walker_checker.
`timescale 1ns / 1ps

module id3v2_frame_walker_tb;

   localparam int KNOWN_ID_COUNT = 84;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 310;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   int failures;
   int pending;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   logic [7:0] file_bytes[$];

   id3v2_frame_walker #(
      .KNOWN_ID_COUNT(KNOWN_ID_COUNT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   id3v2_frame_walker_checker #(
      .KNOWN_ID_COUNT(KNOWN_ID_COUNT)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** id3v2_frame_walker: FAILED **");
         $finish;
      end
   end

   task automatic put_word(input logic [7:0] data_byte, input logic last_byte);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data_byte;
      req_tlast <= last_byte;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) put_word(file_bytes[i], i == file_bytes.size() - 1);
   endtask

   task automatic push_word32(input logic [31:0] value);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(value[8 * k +: 8]);
   endtask

   // Mostly well-formed files of known frames ending in an unknown ID, plus
   // noise, files cut short and frames whose size runs past the end of the file.
   task automatic run_phase(input int idle, input int stall);
      int          sent;
      int          style;
      int          cut;
      int          fill;
      logic [31:0] frame_size;
      logic [31:0] frame_id;
      idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         file_bytes.delete();
         style = $urandom_range(0, 9);
         if (style == 0) begin
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
         end else begin
            repeat (10) file_bytes.push_back(8'($urandom));
            repeat ($urandom_range(0, 3)) begin
               push_word32(id3fw_pkg::KNOWN_IDS[$urandom_range(0, id3fw_pkg::TABLE_IDS - 1)]);
               if (style == 9) frame_size = $urandom;
               else if ($urandom_range(0, 3) == 0) frame_size = 0;
               else frame_size = $urandom_range(1, 8);
               push_word32(frame_size);
               fill = frame_size > 64 ? 64 : int'(frame_size);
               repeat (fill + 2) file_bytes.push_back(8'($urandom));
            end
            case ($urandom_range(0, 1))
               0: frame_id = $urandom;
               default: frame_id =
                  id3fw_pkg::KNOWN_IDS[$urandom_range(0, id3fw_pkg::TABLE_IDS - 1)]
                  ^ (32'h1 << $urandom_range(0, 31));
            endcase
            push_word32(frame_id);
            repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
            if (style == 8) begin
               cut = $urandom_range(1, file_bytes.size());
               while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
         end
         send_file();
         sent += file_bytes.size();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A one-byte file, an unknown ID whose last byte ends the file, and a
      // file that stops right after the tag header.
      file_bytes = {8'hFF};
      send_file();
      file_bytes = {8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h00, 8'h7F,
                    8'h80, 8'hFF, 8'h58, 8'h59, 8'h5A, 8'h21};
      send_file();
      file_bytes = {8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                    8'h80, 8'hFF};
      send_file();

      run_phase(0, 0);
      run_phase(59, 0);
      run_phase(0, 59);
      run_phase(36, 36);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("** id3v2_frame_walker: PASSED **");
      end else begin
         $display("** id3v2_frame_walker: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/id3fw_pkg.sv
hw/rtl/id3fw_id_match.sv
hw/rtl/id3fw_walker.sv
hw/rtl/id3v2_frame_walker.sv
dv/id3v2_frame_walker_checker.sv
dv/id3v2_frame_walker_tb.sv
